/* design/uf2bf_pkg.sv */
// UF2 block framer package: block layout constants, header word codes,
// configuration register indexes and divider types. No dependencies.
`default_nettype none

package uf2bf_pkg;

	localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
	localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
	localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;
	localparam logic [31:0] FAMILY_FLAG  = 32'h0000_2000;

	// 512-byte block = 64 doublewords
	localparam int          BLOCK_WORDS  = 64;
	localparam logic [5:0]  LAST_WORD    = 6'(BLOCK_WORDS - 1);

	// header doubleword slots
	localparam logic [1:0]  HDR_MAGIC    = 2'd0;
	localparam logic [1:0]  HDR_ADDR     = 2'd1;
	localparam logic [1:0]  HDR_COUNT    = 2'd2;
	localparam logic [1:0]  HDR_FAMILY   = 2'd3;

	// configuration register indexes
	localparam logic [1:0]  CFG_BASE     = 2'd0;
	localparam logic [1:0]  CFG_LENGTH   = 2'd1;
	localparam logic [1:0]  CFG_FAM_EN   = 2'd2;
	localparam logic [1:0]  CFG_FAM_ID   = 2'd3;

	typedef logic [31:0] dividend_t;
	typedef logic [31:0] quotient_t;

endpackage

`default_nettype wire

/* design/uf2bf_ceil_div.sv */
// Block count unit: ceil(dividend / DIVISOR) by reciprocal multiplication,
// result registered in the cycle after start. Depends on uf2bf_pkg for the operand types.
`default_nettype none

module uf2bf_ceil_div
	import uf2bf_pkg::*;
#(
	parameter int DIVISOR = 256
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire dividend_t dividend,
	output logic           done,
	output quotient_t      quotient
);

	// floor(n / DIVISOR) = (n * RECIP) >> (32 + SH), exact for every 32-bit n
	localparam int          SH      = $clog2(DIVISOR);
	localparam logic [63:0] RECIP_W = ((64'd1 << (32 + SH)) + 64'(DIVISOR) - 64'd1)
		/ 64'(DIVISOR);
	localparam logic [32:0] RECIP   = RECIP_W[32:0];

	logic [31:0] num;
	logic [64:0] prod;
	logic        done_q;
	quotient_t   quo_q;

	// ceil(d / DIVISOR) = floor((d - 1) / DIVISOR) + 1 for d > 0
	assign num  = dividend - 32'd1;
	assign prod = 65'(num) * 65'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quo_q  <= '0;
		end else begin
			done_q <= start;
			if (start)
				quo_q <= (dividend == '0) ? '0 : 32'(prod >> (32 + SH)) + 32'd1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* design/uf2_block_framer_core.sv */
// UF2 block framer top level: byte stream in, 512-byte UF2 blocks out as doublewords.
// Depends on uf2bf_pkg and uf2bf_ceil_div (block count division).
//
//  channel | dir | payload                                     | handshake
//  s_*     | in  | tdata[7:0] data_byte                        | tvalid/tready
//  m_*     | out | tdata[63:0] block_doubleword, tuser, tlast  | tvalid/tready
//  cfg_*   | in  | cfg_index, cfg_wdata[31:0]                  | cfg_we, no wait
//
// A byte goes through accept, payload count, close check and data word steps. The first
// byte of a block also goes through the block count from the reciprocal multiplier and
// the header words. Closing a block then emits the pad words and the end word.
// s_tready is high only while the sequencer is idle; m_tready low holds the sequencer.
// Reset clears framing state and loads the register defaults.
`default_nettype none

module uf2_block_framer_core
	import uf2bf_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [63:0] block_doubleword
	output logic [1:0]       m_tuser,   // [0] end_of_block, [1] end_of_image
	output logic             m_tlast,   // last_of_run
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	localparam int OW = $clog2(PAYLOAD_BYTES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CNT  = 3'd1;
	localparam logic [2:0] S_CLS  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_HDR  = 3'd4;
	localparam logic [2:0] S_DATA = 3'd5;
	localparam logic [2:0] S_PAD  = 3'd6;

	// configuration
	logic [31:0] base_q, length_q, fam_id_q;
	logic        fam_en_q;

	// framing state
	logic [2:0]    state_q;
	logic [31:0]   taken_q;
	logic [31:0]   blk_num_q;
	logic [39:0]   start_q;
	logic [OW-1:0] offset_q;
	logic [63:0]   word_q;
	logic [2:0]    cnt_q;
	logic          full_q;
	logic [5:0]    wcnt_q;
	logic          hdr_q;
	logic [OW-1:0] count_q;
	logic          close_q;
	logic          emit_q;
	logic          last_q;

	// output register
	logic        ovalid_q;
	logic [63:0] odata_q;
	logic        oeob_q, oeoi_q, olast_q;

	logic        slot;
	logic        load;
	logic        take;
	logic [31:0] remain;
	logic        close_c;
	logic        div_start;
	logic        div_done;
	quotient_t   nblocks;
	logic [63:0] hdr_word;
	logic [31:0] flags, fam;

	assign s_tready  = state_q == S_IDLE;
	assign take      = s_tvalid && s_tready && (taken_q < length_q);
	assign slot      = !ovalid_q || m_tready;
	assign load      = slot && ((state_q == S_HDR) || (state_q == S_PAD) ||
		((state_q == S_DATA) && emit_q));
	assign remain    = (start_q < {8'd0, length_q}) ? length_q - start_q[31:0] : 32'd0;
	assign close_c   = offset_q >= count_q;
	assign div_start = (state_q == S_CLS) && hdr_q;
	assign flags     = fam_en_q ? FAMILY_FLAG : 32'd0;
	assign fam       = fam_en_q ? fam_id_q : 32'd0;

	uf2bf_ceil_div #(
		.DIVISOR(PAYLOAD_BYTES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (length_q),
		.done     (div_done),
		.quotient (nblocks)
	);

	always_comb begin
		case (wcnt_q[1:0])
			HDR_MAGIC:  hdr_word = {MAGIC_START1, MAGIC_START0};
			HDR_ADDR:   hdr_word = {base_q + start_q[31:0], flags};
			HDR_COUNT:  hdr_word = {blk_num_q, 32'(count_q)};
			HDR_FAMILY: hdr_word = {fam, nblocks};
			default:    hdr_word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= 32'h1000_0000;
			length_q <= 32'd1;
			fam_en_q <= 1'b1;
			fam_id_q <= 32'hE48B_FF56;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE:   base_q   <= cfg_wdata;
				CFG_LENGTH: length_q <= cfg_wdata;
				CFG_FAM_EN: fam_en_q <= cfg_wdata[0];
				CFG_FAM_ID: fam_id_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			taken_q   <= '0;
			blk_num_q <= '0;
			start_q   <= '0;
			offset_q  <= '0;
			word_q    <= '0;
			cnt_q     <= '0;
			full_q    <= 1'b0;
			wcnt_q    <= '0;
			hdr_q     <= 1'b0;
			count_q   <= '0;
			close_q   <= 1'b0;
			emit_q    <= 1'b0;
			last_q    <= 1'b0;
			ovalid_q  <= 1'b0;
			odata_q   <= '0;
			oeob_q    <= 1'b0;
			oeoi_q    <= 1'b0;
			olast_q   <= 1'b0;
		end else begin
			if (load)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						word_q[{cnt_q, 3'b000} +: 8] <= s_tdata;
						full_q   <= cnt_q == 3'd7;
						cnt_q    <= cnt_q + 3'd1;
						hdr_q    <= offset_q == '0;
						offset_q <= offset_q + OW'(1);
						taken_q  <= taken_q + 32'd1;
						state_q  <= S_CNT;
					end
				end
				S_CNT: begin
					count_q <= (remain > 32'(PAYLOAD_BYTES)) ? OW'(PAYLOAD_BYTES)
						: remain[OW-1:0];
					state_q <= S_CLS;
				end
				S_CLS: begin
					close_q <= close_c;
					emit_q  <= full_q || (close_c && cnt_q != 3'd0);
					// last block when (block + 1) * payload covers the length
					last_q  <= ({1'b0, start_q} + 41'(PAYLOAD_BYTES)) >= {9'd0, length_q};
					state_q <= hdr_q ? S_DIV : S_DATA;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_HDR;
				end
				S_HDR: begin
					if (slot) begin
						odata_q  <= hdr_word;
						oeob_q   <= 1'b0;
						oeoi_q   <= 1'b0;
						olast_q  <= (wcnt_q[1:0] == HDR_FAMILY) && !emit_q && !close_q;
						wcnt_q   <= wcnt_q + 6'd1;
						if (wcnt_q[1:0] == HDR_FAMILY)
							state_q <= S_DATA;
					end
				end
				S_DATA: begin
					if (!emit_q) begin
						state_q <= close_q ? S_PAD : S_IDLE;
					end else if (slot) begin
						odata_q  <= word_q;
						oeob_q   <= 1'b0;
						oeoi_q   <= 1'b0;
						olast_q  <= !close_q;
						word_q   <= '0;
						cnt_q    <= '0;
						full_q   <= 1'b0;
						wcnt_q   <= wcnt_q + 6'd1;
						state_q  <= close_q ? S_PAD : S_IDLE;
					end
				end
				S_PAD: begin
					if (slot) begin
						if (wcnt_q == LAST_WORD) begin
							odata_q   <= {MAGIC_END, 32'd0};
							oeob_q    <= 1'b1;
							oeoi_q    <= last_q;
							olast_q   <= 1'b1;
							wcnt_q    <= '0;
							blk_num_q <= blk_num_q + 32'd1;
							start_q   <= start_q + 40'(PAYLOAD_BYTES);
							offset_q  <= '0;
							state_q   <= S_IDLE;
						end else begin
							odata_q <= '0;
							oeob_q  <= 1'b0;
							oeoi_q  <= 1'b0;
							olast_q <= 1'b0;
							wcnt_q  <= wcnt_q + 6'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = {oeoi_q, oeob_q};
	assign m_tlast  = olast_q;

endmodule

`default_nettype wire
